// File: rtl/tlsq_pkg.sv
// Package with the shared types and constants of the four-way traffic light sequencer.
`timescale 1ns / 1ps

package tlsq_pkg;

    localparam int unsigned DWELL_W    = 6;
    localparam int unsigned PHASE_W    = 4;
    localparam int unsigned LAMPS_W    = 4;
    localparam int unsigned IN_TDATA_W = 8;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;

    localparam logic [PHASE_W-1:0] PHASE_LAST  = 4'd11;
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd0;
    localparam logic [DWELL_W-1:0] DWELL_RESET = 6'd50;
    localparam logic [DWELL_W-1:0] TICK_RESET  = 6'd1;

    localparam logic [0:0] REG_DWELL_TICKS = 1'b0;

    typedef enum logic [1:0] {
        t_sub_green       = 2'd0,
        t_sub_blink_green = 2'd1,
        t_sub_blink_yellow = 2'd2
    } t_sub_phase;

    typedef struct packed {
        logic button_press;
        logic blink_tick;
        logic phase_tick;
    } t_tick_in;

    typedef struct packed {
        logic               flash_mode;
        logic [PHASE_W-1:0] phase;
        logic [DWELL_W-1:0] tick_count;
        logic               blink_level;
    } t_seq_state;

    typedef struct packed {
        logic [PHASE_W-1:0] current_phase;
        logic               flash_active;
        logic [LAMPS_W-1:0] red_lamps;
        logic [LAMPS_W-1:0] yellow_lamps;
        logic [LAMPS_W-1:0] green_lamps;
    } t_lamp_out;

endpackage

// File: rtl/four_way_traffic_light_sequencer_core.sv
// Top level of the four-way traffic light sequencer with stream and register ports.
//
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tick flags, one transaction per tick
// m_axis    out        m_axis_tvalid/tready      lamp state after that tick
// apb       in         psel/penable/pwrite       dwell_ticks at address 0
//
// Each transaction passes an input register and then a result register.
// One transaction is taken every cycle unless m_axis stalls; the sequencer state updates as
// an item enters the result register, so throughput is set only by the output stall.
// Reset is synchronous and active low and clears the state and both valid flags.
// A stall on m_axis holds the result and backs up into s_axis through tready.
`timescale 1ns / 1ps

module four_way_traffic_light_sequencer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: phase_tick, blink_tick, button_press, zero fill.
    input  logic [tlsq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: green_lamps[3:0], yellow_lamps[7:4], red_lamps[11:8],
    // flash_active[12], current_phase[16:13], zero fill.
    output logic [tlsq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tlsq_pkg::PADDR_W-1:0]        paddr,
    input  logic [tlsq_pkg::PDATA_W-1:0]        pwdata,
    output logic [tlsq_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import tlsq_pkg::*;

    logic [DWELL_W-1:0] r_dwell_ticks;
    logic               r_in_valid;
    t_tick_in           r_in_tick;
    logic               r_out_valid;
    t_lamp_out          r_out_lamps;
    t_seq_state         r_state;

    t_seq_state         n_state;
    t_lamp_out          n_lamps;
    logic               w_advance;
    logic               w_in_accept;
    logic               w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DWELL_TICKS);
    assign prdata      = (paddr[2] == REG_DWELL_TICKS) ?
                         {{(PDATA_W-DWELL_W){1'b0}}, r_dwell_ticks} : '0;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_ticks <= DWELL_RESET;
        end else if (w_cfg_write) begin
            r_dwell_ticks <= pwdata[DWELL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_tick <= t_tick_in'(s_axis_tdata[2:0]);
        end
    end

    tlsq_step u_step (
        .i_state       (r_state),
        .i_tick        (r_in_tick),
        .i_dwell_ticks (r_dwell_ticks),
        .o_state       (n_state),
        .o_lamps       (n_lamps)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.flash_mode  <= 1'b0;
            r_state.phase       <= PHASE_FIRST;
            r_state.tick_count  <= TICK_RESET;
            r_state.blink_level <= 1'b0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_lamps <= n_lamps;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-$bits(t_lamp_out)){1'b0}}, r_out_lamps};

endmodule

// File: rtl/tlsq_step.sv
// Next-state and lamp logic for one tick of the traffic light sequencer.
`timescale 1ns / 1ps

module tlsq_step (
    input  tlsq_pkg::t_seq_state               i_state,
    input  tlsq_pkg::t_tick_in                 i_tick,
    input  logic [tlsq_pkg::DWELL_W-1:0]       i_dwell_ticks,
    output tlsq_pkg::t_seq_state               o_state,
    output tlsq_pkg::t_lamp_out                o_lamps
);
    import tlsq_pkg::*;

    logic [2:0]         w_approach;
    t_sub_phase         w_sub;
    logic [LAMPS_W-1:0] w_bit;

    always_comb begin
        o_state = i_state;
        if (i_tick.blink_tick) begin
            o_state.blink_level = ~i_state.blink_level;
        end
        if (i_tick.button_press) begin
            if (i_state.flash_mode) begin
                o_state.flash_mode = 1'b0;
                o_state.phase      = PHASE_FIRST;
                o_state.tick_count = TICK_RESET;
            end else begin
                o_state.flash_mode = 1'b1;
            end
        end else if (!i_state.flash_mode && i_tick.phase_tick) begin
            if (i_state.tick_count >= i_dwell_ticks) begin
                o_state.phase      = (i_state.phase >= PHASE_LAST) ? PHASE_FIRST
                                                                    : i_state.phase + 4'd1;
                o_state.tick_count = TICK_RESET;
            end else begin
                o_state.tick_count = i_state.tick_count + 6'd1;
            end
        end
    end

    always_comb begin
        case (o_state.phase)
            4'd0:    begin w_approach = 3'd0; w_sub = t_sub_green;        end
            4'd1:    begin w_approach = 3'd0; w_sub = t_sub_blink_green;  end
            4'd2:    begin w_approach = 3'd0; w_sub = t_sub_blink_yellow; end
            4'd3:    begin w_approach = 3'd1; w_sub = t_sub_green;        end
            4'd4:    begin w_approach = 3'd1; w_sub = t_sub_blink_green;  end
            4'd5:    begin w_approach = 3'd1; w_sub = t_sub_blink_yellow; end
            4'd6:    begin w_approach = 3'd2; w_sub = t_sub_green;        end
            4'd7:    begin w_approach = 3'd2; w_sub = t_sub_blink_green;  end
            4'd8:    begin w_approach = 3'd2; w_sub = t_sub_blink_yellow; end
            4'd9:    begin w_approach = 3'd3; w_sub = t_sub_green;        end
            4'd10:   begin w_approach = 3'd3; w_sub = t_sub_blink_green;  end
            4'd11:   begin w_approach = 3'd3; w_sub = t_sub_blink_yellow; end
            4'd12:   begin w_approach = 3'd4; w_sub = t_sub_green;        end
            4'd13:   begin w_approach = 3'd4; w_sub = t_sub_blink_green;  end
            4'd14:   begin w_approach = 3'd4; w_sub = t_sub_blink_yellow; end
            default: begin w_approach = 3'd5; w_sub = t_sub_green;        end
        endcase
    end

    always_comb begin
        w_bit = '0;
        if (!w_approach[2]) begin
            w_bit[w_approach[1:0]] = 1'b1;
        end
    end

    always_comb begin
        o_lamps               = '0;
        o_lamps.flash_active  = o_state.flash_mode;
        o_lamps.current_phase = o_state.phase;
        if (o_state.flash_mode) begin
            o_lamps.yellow_lamps = {LAMPS_W{o_state.blink_level}};
        end else begin
            case (w_sub)
                t_sub_green:        o_lamps.green_lamps  = w_bit;
                t_sub_blink_green:  o_lamps.green_lamps  = w_bit & {LAMPS_W{o_state.blink_level}};
                t_sub_blink_yellow: o_lamps.yellow_lamps = w_bit & {LAMPS_W{o_state.blink_level}};
                default:            o_lamps.green_lamps  = w_bit;
            endcase
            o_lamps.red_lamps = ~w_bit;
        end
    end

endmodule

// File: rtl/tlsq_checker.sv
// Port-level checker for the traffic light sequencer and its bind statement.
`timescale 1ns / 1ps

module tlsq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tlsq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import tlsq_pkg::*;

    t_lamp_out w_lamps;
    assign w_lamps = t_lamp_out'(m_axis_tdata[$bits(t_lamp_out)-1:0]);

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result transaction changed while stalled.");

    a_no_green_on_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_lamps.green_lamps & w_lamps.red_lamps) == '0 &&
                          (w_lamps.yellow_lamps & w_lamps.red_lamps) == '0)
        else $error("An approach shows red together with green or yellow.");

    a_flash_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_lamps.flash_active |->
            w_lamps.green_lamps == '0 && w_lamps.red_lamps == '0 &&
            (w_lamps.yellow_lamps == '0 || w_lamps.yellow_lamps == '1))
        else $error("Flash mode shows lamps other than the common yellow.");

    a_one_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_lamps.flash_active |->
            $countones(w_lamps.red_lamps) == 3 && w_lamps.current_phase <= PHASE_LAST)
        else $error("Normal mode does not serve exactly one approach.");

endmodule

bind four_way_traffic_light_sequencer_core tlsq_checker u_tlsq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: test/tlsq_lamp_checker.sv
// Checker that predicts the lamp outputs of the traffic light sequencer and compares them.
`timescale 1ns / 1ps

module tlsq_lamp_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    input  logic                                i_s_axis_tready,
    input  logic [tlsq_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                                i_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [tlsq_pkg::OUT_TDATA_W-1:0]    i_m_axis_tdata,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [tlsq_pkg::PADDR_W-1:0]        i_paddr,
    input  logic [tlsq_pkg::PDATA_W-1:0]        i_pwdata,
    input  logic [tlsq_pkg::PDATA_W-1:0]        i_prdata,
    input  logic                                i_pready,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    import tlsq_pkg::*;

    localparam logic [PADDR_W-1:0] DWELL_ADDR = PADDR_W'(4 * REG_DWELL_TICKS);
    localparam int unsigned LAMP_BITS = $bits(t_lamp_out);

    logic [DWELL_W-1:0] dwell_cfg;
    logic               flashing;
    logic [PHASE_W-1:0] phase_now;
    logic [DWELL_W-1:0] dwell_count;
    logic               blink_on;

    t_lamp_out expected_lamps[$];
    int        fail_count = 0;
    int        checked_count = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked_count;

    function automatic t_lamp_out advance_lights(input t_tick_in tick);
        t_lamp_out          lamps;
        logic [LAMPS_W-1:0] lane;
        t_sub_phase         sub;
        if (tick.blink_tick) begin
            blink_on = !blink_on;
        end
        if (tick.button_press) begin
            if (flashing) begin
                flashing    = 1'b0;
                phase_now   = PHASE_FIRST;
                dwell_count = TICK_RESET;
            end else begin
                flashing = 1'b1;
            end
        end else if (!flashing && tick.phase_tick) begin
            if (dwell_count >= dwell_cfg) begin
                phase_now   = (phase_now >= PHASE_LAST) ? PHASE_FIRST : phase_now + 1'b1;
                dwell_count = TICK_RESET;
            end else begin
                dwell_count = dwell_count + 1'b1;
            end
        end
        lamps = '0;
        if (flashing) begin
            lamps.yellow_lamps = blink_on ? '1 : '0;
        end else begin
            lane = LAMPS_W'(1) << (phase_now / 3);
            sub  = t_sub_phase'(phase_now % 3);
            case (sub)
                t_sub_green: begin
                    lamps.green_lamps = lane;
                end
                t_sub_blink_green: begin
                    lamps.green_lamps = blink_on ? lane : '0;
                end
                default: begin
                    lamps.yellow_lamps = blink_on ? lane : '0;
                end
            endcase
            lamps.red_lamps = ~lane;
        end
        lamps.flash_active  = flashing;
        lamps.current_phase = phase_now;
        return lamps;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lamp_out want;
        t_lamp_out got;
        if (!i_rst_n) begin
            dwell_cfg   = DWELL_RESET;
            flashing    = 1'b0;
            phase_now   = PHASE_FIRST;
            dwell_count = TICK_RESET;
            blink_on    = 1'b0;
            expected_lamps.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == DWELL_ADDR) begin
                if (i_pwrite) begin
                    dwell_cfg = i_pwdata[DWELL_W-1:0];
                end else begin
                    compare_field("prdata", PDATA_W'(dwell_cfg), i_prdata);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_lamps.push_back(
                    advance_lights(t_tick_in'(i_s_axis_tdata[$bits(t_tick_in)-1:0])));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_lamp_out'(i_m_axis_tdata[LAMP_BITS-1:0]);
                if (expected_lamps.size() == 0) begin
                    $error("lamp transaction 0x%0h arrived with no expectation pending",
                           i_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_lamps.pop_front();
                    compare_field("green_lamps", want.green_lamps, got.green_lamps);
                    compare_field("yellow_lamps", want.yellow_lamps, got.yellow_lamps);
                    compare_field("red_lamps", want.red_lamps, got.red_lamps);
                    compare_field("flash_active", want.flash_active, got.flash_active);
                    compare_field("current_phase", want.current_phase, got.current_phase);
                    compare_field("zero_fill", 0, i_m_axis_tdata[OUT_TDATA_W-1:LAMP_BITS]);
                    checked_count++;
                end
            end
        end
        o_pending <= expected_lamps.size();
    end

endmodule

// File: test/four_way_traffic_light_sequencer_core_test.sv
// Testbench top that drives tick and register traffic into the sequencer and reports the verdict.
`timescale 1ns / 1ps

module four_way_traffic_light_sequencer_core_test;
    import tlsq_pkg::*;

    localparam logic [PADDR_W-1:0] DWELL_ADDR = PADDR_W'(4 * REG_DWELL_TICKS);
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    int fail_count;
    int pending_results;
    int checked_results;
    int cycle_count = 0;
    int press_count = 0;
    int setting_count = 0;
    int hold_requests = 0;
    int holds_served = 0;
    bit steady_run = 1'b0;

    four_way_traffic_light_sequencer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tlsq_lamp_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results),
        .o_checked       (checked_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("four_way_traffic_light_sequencer_core regression: fail");
            $finish;
        end
    end

    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= steady_run || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    task automatic send_tick(input logic phase_tick, input logic blink_tick,
                             input logic button_press);
        if (!steady_run) begin
            while ($urandom_range(0, 99) < 25) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({button_press, blink_tick, phase_tick});
        if (button_press) begin
            press_count++;
        end
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [DWELL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= DWELL_ADDR;
        pwdata  <= ($urandom() & ~PDATA_W'('h3F)) | PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_dwell(input logic [DWELL_W-1:0] value);
        drain_results();
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
        setting_count++;
    endtask

    task automatic run_ticks(input int count, input int press_pct);
        for (int n = 0; n < count; n++) begin
            send_tick($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 30,
                      $urandom_range(0, 99) < press_pct);
        end
    endtask

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset dwell: blink toggling, flash entry with a competing phase tick, and exit.
        apb_access(1'b0, '0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);

        // One tick per sub-phase walks every approach and wraps back to the first.
        set_dwell(6'd1);
        for (int n = 0; n < 13; n++) begin
            send_tick(1'b1, n[0], 1'b0);
        end
        send_tick(1'b1, 1'b1, 1'b1);

        set_dwell(6'd1);
        run_ticks(100, 3);
        hold_requests++;
        run_ticks(150, 3);

        set_dwell(6'd0);
        run_ticks(150, 3);

        set_dwell(6'd63);
        run_ticks(350, 1);
        drain_results();
        run_ticks(350, 1);

        set_dwell(6'd2);
        steady_run = 1'b1;
        run_ticks(250, 3);
        steady_run = 1'b0;

        set_dwell(DWELL_W'($urandom_range(3, 8)));
        run_ticks(250, 3);

        set_dwell(DWELL_RESET);
        run_ticks(150, 20);

        set_dwell(DWELL_W'($urandom_range(1, 63)));
        run_ticks(200, 2);

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d lamp transactions over %0d dwell settings.",
                 checked_results, setting_count);
        $display("Mode button pressed %0d times; output stall and full drain included.",
                 press_count);
        if (fail_count == 0) begin
            $display("four_way_traffic_light_sequencer_core regression: pass");
        end else begin
            $display("four_way_traffic_light_sequencer_core regression: fail");
        end
        $finish;
    end

endmodule
